// ===== sv/bpfh_pkg.sv =====
package bpfh_pkg;

  localparam int BIN_W      = 11;
  localparam int SAMPLE_W   = 24;
  localparam int MAG_SQ_W   = 2 * SAMPLE_W;
  localparam int POWER_W    = MAG_SQ_W + 1;
  localparam int NUM_BANDS  = 4;
  localparam int BAND_W     = 2;
  localparam int FRAME_W    = 32;
  localparam int HASH_W     = 38;
  localparam int WEIGHT_W   = 27;
  localparam int FRAME_BINS = 2048;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = 1;
  localparam int Q_CNT_W    = 2;
  localparam int DIV_CNT_W  = 4;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_BIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_ZERO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_ONE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_TWO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FUZZ      = 3'd6;

  localparam logic [WEIGHT_W-1:0] HASH_WEIGHT [NUM_BANDS] = '{
    27'd1, 27'd100, 27'd100000, 27'd100000000
  };

  typedef struct packed {
    logic [BIN_W-1:0] first_bin;
    logic [BIN_W-1:0] last_bin;
    logic [BIN_W-1:0] edge_zero;
    logic [BIN_W-1:0] edge_one;
    logic [BIN_W-1:0] edge_two;
    logic [BIN_W-1:0] edge_three;
    logic [BIN_W-1:0] fuzz;
  } cfg_t;

  typedef struct packed {
    logic [NUM_BANDS-1:0][BIN_W-1:0] peak;
    logic [FRAME_W-1:0]              frame;
  } frame_rec_t;

  typedef struct packed {
    logic push;
  } q_wr_ctl_t;

  typedef struct packed {
    logic empty;
  } q_rd_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_DONE = 4'b1000
  } back_state_t;

endpackage

// ===== sv/bpfh_front.sv =====
module bpfh_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bpfh_pkg::cfg_t                    cfg,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bpfh_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tlast,
  input  logic                              q_full,
  output logic                              q_push,
  output bpfh_pkg::frame_rec_t              q_wdata
);
  import bpfh_pkg::*;

  logic                in_fire;
  logic [BIN_W-1:0]    idx;
  logic [SAMPLE_W-1:0] re_raw;
  logic [SAMPLE_W-1:0] im_raw;
  logic [SAMPLE_W-1:0] re_mag;
  logic [SAMPLE_W-1:0] im_mag;
  logic                hit;
  logic [BAND_W-1:0]   band;
  logic                adv;

  logic                s1_valid_r;
  logic                s1_last_r;
  logic                s1_hit_r;
  logic [BAND_W-1:0]   s1_band_r;
  logic [BIN_W-1:0]    s1_idx_r;
  logic [SAMPLE_W-1:0] s1_re_r;
  logic [SAMPLE_W-1:0] s1_im_r;

  logic                s2_valid_r;
  logic                s2_last_r;
  logic                s2_hit_r;
  logic [BAND_W-1:0]   s2_band_r;
  logic [BIN_W-1:0]    s2_idx_r;
  logic [MAG_SQ_W-1:0] s2_re2_r;
  logic [MAG_SQ_W-1:0] s2_im2_r;

  logic [NUM_BANDS-1:0][POWER_W-1:0] best_r;
  logic [NUM_BANDS-1:0][POWER_W-1:0] best_nxt;
  logic [NUM_BANDS-1:0][BIN_W-1:0]   peak_r;
  logic [NUM_BANDS-1:0][BIN_W-1:0]   peak_upd;
  logic [NUM_BANDS-1:0][BIN_W-1:0]   peak_nxt;
  logic [FRAME_W-1:0]                frame_r;
  logic [POWER_W-1:0]                power;
  logic                              better;

  assign adv       = !q_full;
  assign in_tready = adv;
  assign in_fire   = in_tvalid && in_tready;

  assign idx    = in_tdata[BIN_W-1:0];
  assign re_raw = in_tdata[BIN_W +: SAMPLE_W];
  assign im_raw = in_tdata[BIN_W+SAMPLE_W +: SAMPLE_W];

  always_comb begin
    re_mag = re_raw[SAMPLE_W-1] ? (~re_raw + 1'b1) : re_raw;
    im_mag = im_raw[SAMPLE_W-1] ? (~im_raw + 1'b1) : im_raw;
    hit    = ({1'b0, idx} < 12'(FRAME_BINS)) && (idx >= cfg.first_bin) &&
             (idx <= cfg.last_bin) && (idx <= cfg.edge_zero || idx <= cfg.edge_one ||
             idx <= cfg.edge_two || idx <= cfg.edge_three);
    if (idx <= cfg.edge_zero) begin
      band = 2'd0;
    end else if (idx <= cfg.edge_one) begin
      band = 2'd1;
    end else if (idx <= cfg.edge_two) begin
      band = 2'd2;
    end else begin
      band = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_fire;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last_r <= in_tlast;
      s1_hit_r  <= hit;
      s1_band_r <= band;
      s1_idx_r  <= idx;
      s1_re_r   <= re_mag;
      s1_im_r   <= im_mag;
      s2_last_r <= s1_last_r;
      s2_hit_r  <= s1_hit_r;
      s2_band_r <= s1_band_r;
      s2_idx_r  <= s1_idx_r;
      s2_re2_r  <= s1_re_r * s1_re_r;
      s2_im2_r  <= s1_im_r * s1_im_r;
    end
  end

  assign power  = {1'b0, s2_re2_r} + {1'b0, s2_im2_r};
  assign better = s2_valid_r && s2_hit_r && (power > best_r[s2_band_r]);
  assign q_push = adv && s2_valid_r && s2_last_r;

  always_comb begin
    peak_upd = peak_r;
    best_nxt = best_r;
    if (better) begin
      peak_upd[s2_band_r] = s2_idx_r;
      best_nxt[s2_band_r] = power;
    end
    peak_nxt = peak_upd;
    if (q_push) begin
      peak_nxt = '0;
      best_nxt = '0;
    end
  end

  assign q_wdata.peak  = peak_upd;
  assign q_wdata.frame = frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r  <= '0;
      peak_r  <= '0;
      frame_r <= '0;
    end else if (adv) begin
      best_r <= best_nxt;
      peak_r <= peak_nxt;
      if (q_push) begin
        frame_r <= frame_r + 1'b1;
      end
    end
  end

endmodule

// ===== sv/bpfh_queue.sv =====
module bpfh_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bpfh_pkg::q_wr_ctl_t  wr_ctl_in,
  output logic                 full,
  input  bpfh_pkg::frame_rec_t wdata,
  input  logic                 pop,
  output bpfh_pkg::q_rd_ctl_t  rd_ctl_out,
  output bpfh_pkg::frame_rec_t rdata
);
  import bpfh_pkg::*;

  frame_rec_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic [Q_CNT_W-1:0] count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full             = (count_r == Q_CNT_W'(Q_DEPTH));
  assign rd_ctl_out.empty = (count_r == '0);
  assign do_push          = wr_ctl_in.push && !full;
  assign do_pop           = pop && !rd_ctl_out.empty;
  assign rdata            = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// ===== sv/bpfh_back.sv =====
module bpfh_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [bpfh_pkg::BIN_W-1:0]       fuzz,
  input  bpfh_pkg::q_rd_ctl_t              q_ctl,
  output logic                             q_pop,
  input  bpfh_pkg::frame_rec_t             q_rdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bpfh_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bpfh_pkg::*;

  back_state_t                     state_r;
  back_state_t                     state_nxt;
  logic [NUM_BANDS-1:0][BIN_W-1:0] peak_r;
  logic [NUM_BANDS-1:0][BIN_W-1:0] num_r;
  logic [NUM_BANDS-1:0][BIN_W-1:0] rem_r;
  logic [NUM_BANDS-1:0][BIN_W-1:0] rem_nxt;
  logic [NUM_BANDS-1:0][BIN_W-1:0] rounded;
  logic [BIN_W-1:0]                fuzz_r;
  logic [FRAME_W-1:0]              frame_r;
  logic [DIV_CNT_W-1:0]            cnt_r;
  logic [HASH_W-1:0]               acc_r;
  logic [HASH_W-1:0]               prod;
  logic [BIN_W:0]                  trial [NUM_BANDS];
  logic                            out_valid_r;
  logic [HASH_W-1:0]               out_hash_r;
  logic [FRAME_W-1:0]              out_frame_r;
  logic                            out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign q_pop      = (state_r == ST_IDLE) && !q_ctl.empty;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - HASH_W - FRAME_W){1'b0}}, out_frame_r, out_hash_r};

  always_comb begin
    for (int k = 0; k < NUM_BANDS; k++) begin
      trial[k] = {rem_r[k], num_r[k][BIN_W-1]};
      if (trial[k] >= {1'b0, fuzz_r}) begin
        rem_nxt[k] = BIN_W'(trial[k] - {1'b0, fuzz_r});
      end else begin
        rem_nxt[k] = trial[k][BIN_W-1:0];
      end
      rounded[k] = peak_r[k] - rem_r[k];
    end
  end

  assign prod = HASH_W'({{(HASH_W - BIN_W){1'b0}}, rounded[cnt_r[BAND_W-1:0]]} *
                        {{(HASH_W - WEIGHT_W){1'b0}}, HASH_WEIGHT[cnt_r[BAND_W-1:0]]});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_ctl.empty) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == DIV_CNT_W'(BIN_W - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_r == DIV_CNT_W'(NUM_BANDS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r != state_nxt) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        peak_r  <= q_rdata.peak;
        num_r   <= q_rdata.peak;
        rem_r   <= '0;
        frame_r <= q_rdata.frame;
        fuzz_r  <= (fuzz == '0) ? BIN_W'(1) : fuzz;
        acc_r   <= '0;
      end
      ST_DIV: begin
        rem_r <= rem_nxt;
        for (int k = 0; k < NUM_BANDS; k++) begin
          num_r[k] <= {num_r[k][BIN_W-2:0], 1'b0};
        end
      end
      ST_MUL: begin
        acc_r <= acc_r + prod;
      end
      ST_DONE: begin
        if (out_free) begin
          out_hash_r  <= (acc_r == '0) ? HASH_W'(1) : acc_r;
          out_frame_r <= frame_r;
        end
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

endmodule

// ===== sv/band_peak_fingerprint_hash.sv =====
// Band peak fingerprint hash. FFT bins enter on the in_ stream, one transaction per bin,
// with tlast marking the last bin of a frame. Bins inside the scanned range are sorted
// into four bands by the edge registers, and each band keeps its strongest bin.
// On the last bin of a frame the four peaks, rounded down to a multiple of the fuzz
// factor, are combined into one hash that leaves on the out_ stream with the frame
// number; the band peaks then clear for the next frame.
// The input takes one bin per cycle while the queue is not full. A three-stage front
// updates the band peaks and hands each finished frame to a two-entry queue. The back
// end takes one frame at a time from the queue through a load step, a bit-serial
// remainder of all four peaks by the fuzz factor and one multiply-accumulate per band.
// If the receiver stalls, the finished hash waits in the output register while the
// back end prepares the next one; once two frames are queued behind it, in_tready
// falls until the back end takes the next frame from the queue. Configuration writes
// take effect at once; the user must make them only while the block is idle (no check).
// Reset (rst_n low, synchronous) restores the register defaults, clears the band
// peaks, the frame counter, the queue and the output stream.
module band_peak_fingerprint_hash (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bpfh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpfh_pkg::BIN_W-1:0]       cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // bin_index [10:0], bin_real [34:11], bin_imag [58:35], zero fill above
  input  logic [bpfh_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // fingerprint_hash [37:0], frame_number [69:38], zero fill above
  output logic [bpfh_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bpfh_pkg::*;

  cfg_t       cfg_r;
  q_wr_ctl_t  wr_ctl;
  q_rd_ctl_t  rd_ctl;
  frame_rec_t q_wdata;
  frame_rec_t q_rdata;
  logic       q_full;
  logic       q_push;
  logic       q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_bin  <= 11'd40;
      cfg_r.last_bin   <= 11'd298;
      cfg_r.edge_zero  <= 11'd40;
      cfg_r.edge_one   <= 11'd80;
      cfg_r.edge_two   <= 11'd120;
      cfg_r.edge_three <= 11'd180;
      cfg_r.fuzz       <= 11'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_BIN: cfg_r.first_bin  <= cfg_wdata;
        REG_LAST_BIN:  cfg_r.last_bin   <= cfg_wdata;
        REG_EDGE_ZERO: cfg_r.edge_zero  <= cfg_wdata;
        REG_EDGE_ONE:  cfg_r.edge_one   <= cfg_wdata;
        REG_EDGE_TWO:  cfg_r.edge_two   <= cfg_wdata;
        REG_EDGE_THR:  cfg_r.edge_three <= cfg_wdata;
        REG_FUZZ:      cfg_r.fuzz       <= cfg_wdata;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  assign wr_ctl.push = q_push;

  bpfh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  bpfh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_ctl_in  (wr_ctl),
    .full       (q_full),
    .wdata      (q_wdata),
    .pop        (q_pop),
    .rd_ctl_out (rd_ctl),
    .rdata      (q_rdata)
  );

  bpfh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fuzz       (cfg_r.fuzz),
    .q_ctl      (rd_ctl),
    .q_pop      (q_pop),
    .q_rdata    (q_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
